// ===== src/cdfs_pkg.sv =====
// cdfs_pkg: shared widths, register indexes, format and mode codes and
// geometry types for the crop / decimate / flip pixel sampler.
// No dependencies.
package cdfs_pkg;

   // default largest frame dimension
   localparam int MAX_DIM_DEFAULT = 4096;

   // payload and register widths
   localparam int PIXEL_W    = 32;
   localparam int COLOR_W    = 8;
   localparam int COORD_W    = 12;
   localparam int DIM_CFG_W  = 13;
   localparam int CROP_W     = 12;
   localparam int DEC_W      = 16;
   localparam int CTRL_W     = 7;
   localparam int STEP_W     = 8;
   localparam int FMT_W      = 3;
   localparam int FLIP_W     = 2;
   localparam int MODE_W     = 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_LEFT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_RIGHT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_TOP     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_BOTTOM  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DECIMATION   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CONTROL      = 3'd7;

   // register reset values
   localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [DEC_W-1:0]     DECIMATION_RESET   = 16'd2056;

   // pixel formats
   localparam logic [FMT_W-1:0] FMT_RGB24 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_BGR24 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGB32 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_BGR32 = 3'd3;
   localparam logic [FMT_W-1:0] FMT_BGR16 = 3'd4;

   // 3D video modes
   localparam logic [MODE_W-1:0] MODE_SBS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TAB = 2'd2;

   // flip control bits
   localparam int FLIP_ROWS_BIT = 0;
   localparam int FLIP_COLS_BIT = 1;

   // control register fields
   localparam int CTRL_FMT_LSB  = 0;
   localparam int CTRL_FLIP_LSB = 3;
   localparam int CTRL_MODE_LSB = 5;

   // geometry sequencer states
   typedef enum logic [1:0] {
      GEOM_LOAD,
      GEOM_DIVIDE,
      GEOM_READY
   } geom_state_type;

   // geometry sequencer controls
   typedef struct packed {
      logic load;
      logic step;
      logic ready;
   } geom_ctrl_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   // unpack one raw pixel word into 8-bit components
   function automatic rgb_type unpack_pixel(input logic [FMT_W-1:0] fmt,
                                            input logic [PIXEL_W-1:0] px);
      rgb_type c;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      b0 = px[7:0];
      b1 = px[15:8];
      b2 = px[23:16];
      c = '0;
      case (fmt)
         FMT_RGB24, FMT_RGB32: begin
            c.red = b0;
            c.green = b1;
            c.blue = b2;
         end
         FMT_BGR24, FMT_BGR32: begin
            c.blue = b0;
            c.green = b1;
            c.red = b2;
         end
         FMT_BGR16: begin
            c.blue = {b0[4:0], 3'b000};
            c.green = {b1[2:0], b0[7:5], 2'b00};
            c.red = {b1[7:3], 3'b000};
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== src/cdfs_ifs.sv =====
// cdfs_req_if / cdfs_rsp_if: valid/ready channels of the pixel sampler.
// Depends on cdfs_pkg for payload widths.
interface cdfs_req_if;
   logic                          valid;
   logic                          ready;
   logic [cdfs_pkg::PIXEL_W-1:0]  pixel_bytes;
   logic                          frame_start;

   modport source (output valid, output pixel_bytes, output frame_start, input ready);
   modport sink (input valid, input pixel_bytes, input frame_start, output ready);
endinterface

interface cdfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cdfs_pkg::COLOR_W-1:0]  red;
   logic [cdfs_pkg::COLOR_W-1:0]  green;
   logic [cdfs_pkg::COLOR_W-1:0]  blue;
   logic [cdfs_pkg::COORD_W-1:0]  dest_x;
   logic [cdfs_pkg::COORD_W-1:0]  dest_y;
   logic                          frame_last;

   modport source (output valid, output red, output green, output blue, output dest_x,
                   output dest_y, output frame_last, input ready);
   modport sink (input valid, input red, input green, input blue, input dest_x,
                 input dest_y, input frame_last, output ready);
endinterface

// ===== src/crop_decimate_flip_rgb_sampler_core.sv =====
// crop_decimate_flip_rgb_sampler_core: crops, decimates, flips and converts
// a raster pixel stream to 8-bit RGB. Depends on cdfs_pkg and cdfs_ifs.
//
// Usage:
//   req_ch carries one raw source pixel word per transfer, in raster order,
//   with frame_start set on the first pixel of each frame. rsp_ch carries
//   one sampled RGB pixel with its destination column and row and a mark on
//   the last output pixel of the frame. Pixels outside the crop window or off
//   the decimation grid produce no transfer on rsp_ch.
//   The csr_ port writes one register per cycle; the values take effect at
//   the next frame start.
//   A pixel accepted on req_ch waits in the input register, then is sampled
//   and registered into the result register that drives rsp_ch.
//   Throughput: one pixel per cycle unless rsp_ch stalls or the geometry is
//   being recomputed; set by the single input and result registers.
//   The output size per frame needs a division by the decimation step; a
//   shared-timing serial divider (one quotient bit per cycle, two lanes for
//   width and height) recomputes it after reset and after every register
//   write, and req_ch is not ready while it runs.
//   Reset restores the register defaults and clears all counters; no output
//   is produced until the first frame start.
//   When rsp_ch stalls the result is held, one more pixel is taken into the
//   input register, and then req_ch drops ready until the result moves.
module crop_decimate_flip_rgb_sampler_core #(
   parameter int MAX_DIM = cdfs_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   cdfs_req_if.sink                          req_ch,
   cdfs_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_en,
   input  logic [cdfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cdfs_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int AW    = ((DW > cdfs_pkg::DIM_CFG_W) ? DW : cdfs_pkg::DIM_CFG_W) + 3;
   localparam int NW    = AW - 1;
   localparam int CNT_W = $clog2(NW + 1);
   localparam int SW    = cdfs_pkg::STEP_W;
   localparam logic [DW-1:0] MAX_DIM_D = DW'(MAX_DIM);
   localparam logic [NW-1:0] MAX_DIM_N = NW'(MAX_DIM);

   // configuration registers
   logic [cdfs_pkg::DIM_CFG_W-1:0] frame_width_ff;
   logic [cdfs_pkg::DIM_CFG_W-1:0] frame_height_ff;
   logic [cdfs_pkg::CROP_W-1:0]    crop_left_ff;
   logic [cdfs_pkg::CROP_W-1:0]    crop_right_ff;
   logic [cdfs_pkg::CROP_W-1:0]    crop_top_ff;
   logic [cdfs_pkg::CROP_W-1:0]    crop_bottom_ff;
   logic [cdfs_pkg::DEC_W-1:0]     decimation_ff;
   logic [cdfs_pkg::CTRL_W-1:0]    control_ff;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= cdfs_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= cdfs_pkg::FRAME_HEIGHT_RESET;
         crop_left_ff <= '0;
         crop_right_ff <= '0;
         crop_top_ff <= '0;
         crop_bottom_ff <= '0;
         decimation_ff <= cdfs_pkg::DECIMATION_RESET;
         control_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            cdfs_pkg::REG_FRAME_WIDTH:  frame_width_ff <= csr_write_data[cdfs_pkg::DIM_CFG_W-1:0];
            cdfs_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_write_data[cdfs_pkg::DIM_CFG_W-1:0];
            cdfs_pkg::REG_CROP_LEFT:    crop_left_ff <= csr_write_data[cdfs_pkg::CROP_W-1:0];
            cdfs_pkg::REG_CROP_RIGHT:   crop_right_ff <= csr_write_data[cdfs_pkg::CROP_W-1:0];
            cdfs_pkg::REG_CROP_TOP:     crop_top_ff <= csr_write_data[cdfs_pkg::CROP_W-1:0];
            cdfs_pkg::REG_CROP_BOTTOM:  crop_bottom_ff <= csr_write_data[cdfs_pkg::CROP_W-1:0];
            cdfs_pkg::REG_DECIMATION:   decimation_ff <= csr_write_data[cdfs_pkg::DEC_W-1:0];
            cdfs_pkg::REG_CONTROL:      control_ff <= csr_write_data[cdfs_pkg::CTRL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // frame geometry from the registers
   logic signed [AW-1:0] w_s, h_s, cl_s, cr_s, ct_s, cb_s, hd_s, vd_s;
   logic signed [AW-1:0] num_x, num_y;
   logic [SW-1:0]        hd, vd;
   logic [cdfs_pkg::MODE_W-1:0] mode;
   logic [NW-1:0]        dividend_x, dividend_y;
   logic [AW-1:0]        first_col, first_row;

   always_comb begin
      mode = control_ff[cdfs_pkg::CTRL_MODE_LSB +: cdfs_pkg::MODE_W];
      w_s = AW'(frame_width_ff);
      if (frame_width_ff == '0) begin
         w_s = AW'(1);
      end else if (w_s > AW'(MAX_DIM)) begin
         w_s = AW'(MAX_DIM);
      end
      h_s = AW'(frame_height_ff);
      if (frame_height_ff == '0) begin
         h_s = AW'(1);
      end else if (h_s > AW'(MAX_DIM)) begin
         h_s = AW'(MAX_DIM);
      end
      hd = (decimation_ff[SW-1:0] == '0) ? SW'(1) : decimation_ff[SW-1:0];
      vd = (decimation_ff[2*SW-1:SW] == '0) ? SW'(1) : decimation_ff[2*SW-1:SW];
      hd_s = AW'(hd);
      vd_s = AW'(vd);
      cl_s = AW'(crop_left_ff);
      cr_s = AW'(crop_right_ff);
      ct_s = AW'(crop_top_ff);
      cb_s = AW'(crop_bottom_ff);
      // 3D halves one axis
      if (mode == cdfs_pkg::MODE_SBS) begin
         cr_s = (w_s >>> 1) + (cr_s >>> 1);
         cl_s = cl_s >>> 1;
      end else if (mode == cdfs_pkg::MODE_TAB) begin
         cb_s = (h_s >>> 1) + (cb_s >>> 1);
         ct_s = ct_s >>> 1;
      end
      num_x = w_s - cl_s - cr_s - (hd_s >>> 1) + hd_s - AW'(1);
      num_y = h_s - ct_s - cb_s - (vd_s >>> 1) + vd_s - AW'(1);
      dividend_x = (num_x > AW'(0)) ? num_x[NW-1:0] : '0;
      dividend_y = (num_y > AW'(0)) ? num_y[NW-1:0] : '0;
      first_col = AW'(cl_s + (hd_s >>> 1));
      first_row = AW'(ct_s + (vd_s >>> 1));
   end

   // geometry sequencer
   cdfs_pkg::geom_state_type geom_state_ff, geom_state_in;
   cdfs_pkg::geom_ctrl_type  geom_ctrl;
   logic [CNT_W-1:0]         div_cnt_ff, div_cnt_in;

   always_comb begin
      geom_state_in = geom_state_ff;
      case (geom_state_ff)
         cdfs_pkg::GEOM_LOAD:   geom_state_in = cdfs_pkg::GEOM_DIVIDE;
         cdfs_pkg::GEOM_DIVIDE: begin
            if (div_cnt_ff == CNT_W'(NW - 1)) begin
               geom_state_in = cdfs_pkg::GEOM_READY;
            end
         end
         cdfs_pkg::GEOM_READY:  geom_state_in = cdfs_pkg::GEOM_READY;
         default:               geom_state_in = cdfs_pkg::GEOM_LOAD;
      endcase
      if (csr_write_en) begin
         geom_state_in = cdfs_pkg::GEOM_LOAD;
      end
   end

   always_comb begin
      geom_ctrl = '0;
      case (geom_state_ff)
         cdfs_pkg::GEOM_LOAD:   geom_ctrl.load = 1'b1;
         cdfs_pkg::GEOM_DIVIDE: geom_ctrl.step = 1'b1;
         cdfs_pkg::GEOM_READY:  geom_ctrl.ready = 1'b1;
         default:               geom_ctrl = '0;
      endcase
   end

   assign div_cnt_in = geom_ctrl.step ? div_cnt_ff + CNT_W'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_state_ff <= cdfs_pkg::GEOM_LOAD;
         div_cnt_ff <= '0;
      end else begin
         geom_state_ff <= geom_state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // latched geometry and serial divider, lane 0 width, lane 1 height
   logic [DW-1:0]               geo_w_ff;
   logic [SW-1:0]               geo_hstep_ff, geo_vstep_ff;
   logic [AW-1:0]               geo_first_col_ff, geo_first_row_ff;
   logic [cdfs_pkg::FMT_W-1:0]  geo_format_ff;
   logic [cdfs_pkg::FLIP_W-1:0] geo_flip_ff;
   logic [NW-1:0]               div_q_ff [2];
   logic [NW-1:0]               div_q_in [2];
   logic [SW-1:0]               div_rem_ff [2];
   logic [SW-1:0]               div_rem_in [2];
   logic [SW-1:0]               div_den [2];
   logic [SW:0]                 div_trial [2];
   logic [DW-1:0]               geo_size [2];

   assign div_den[0] = geo_hstep_ff;
   assign div_den[1] = geo_vstep_ff;

   // one restoring step per lane, then the size cap
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         div_trial[l] = {div_rem_ff[l], div_q_ff[l][NW-1]};
         if (div_trial[l] >= {1'b0, div_den[l]}) begin
            div_rem_in[l] = SW'(div_trial[l] - {1'b0, div_den[l]});
            div_q_in[l] = {div_q_ff[l][NW-2:0], 1'b1};
         end else begin
            div_rem_in[l] = div_trial[l][SW-1:0];
            div_q_in[l] = {div_q_ff[l][NW-2:0], 1'b0};
         end
         geo_size[l] = (div_q_ff[l] > MAX_DIM_N) ? MAX_DIM_D : div_q_ff[l][DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (geom_ctrl.load) begin
         geo_w_ff <= w_s[DW-1:0];
         geo_hstep_ff <= hd;
         geo_vstep_ff <= vd;
         geo_first_col_ff <= first_col;
         geo_first_row_ff <= first_row;
         geo_format_ff <= control_ff[cdfs_pkg::CTRL_FMT_LSB +: cdfs_pkg::FMT_W];
         geo_flip_ff <= control_ff[cdfs_pkg::CTRL_FLIP_LSB +: cdfs_pkg::FLIP_W];
         div_q_ff[0] <= dividend_x;
         div_q_ff[1] <= dividend_y;
         div_rem_ff[0] <= '0;
         div_rem_ff[1] <= '0;
      end else if (geom_ctrl.step) begin
         div_q_ff <= div_q_in;
         div_rem_ff <= div_rem_in;
      end
   end

   // input register and transfer control
   logic                          in_v_ff, in_v_in;
   logic [cdfs_pkg::PIXEL_W-1:0]  in_px_ff;
   logic                          in_fs_ff;
   logic                          out_v_ff, out_v_in;
   logic                          advance;
   logic                          req_take;
   logic                          hit;

   assign advance  = in_v_ff && geom_ctrl.ready && (!out_v_ff || rsp_ch.ready);
   assign req_ch.ready = geom_ctrl.ready && (!in_v_ff || advance);
   assign req_take = req_ch.valid && req_ch.ready;
   assign in_v_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_v_ff);

   always_comb begin
      out_v_in = out_v_ff;
      if (advance) begin
         out_v_in = hit;
      end else if (rsp_ch.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_px_ff <= req_ch.pixel_bytes;
         in_fs_ff <= req_ch.frame_start;
      end
   end

   // frame counters and latched frame settings
   logic [DW-1:0]               src_col_ff, src_row_ff, out_col_ff, out_row_ff;
   logic [AW-1:0]               next_col_ff, next_row_ff;
   logic [SW-1:0]               lat_hstep_ff, lat_vstep_ff;
   logic [AW-1:0]               lat_first_col_ff;
   logic [cdfs_pkg::FMT_W-1:0]  lat_format_ff;
   logic [cdfs_pkg::FLIP_W-1:0] lat_flip_ff;
   logic [DW-1:0]               lat_width_ff, out_width_ff, out_height_ff;

   // current view, with frame start applied
   logic [DW-1:0]               cur_src_col, cur_src_row, cur_out_col, cur_out_row;
   logic [AW-1:0]               cur_next_col, cur_next_row;
   logic [SW-1:0]               cur_hstep, cur_vstep;
   logic [AW-1:0]               cur_first_col;
   logic [cdfs_pkg::FMT_W-1:0]  cur_format;
   logic [cdfs_pkg::FLIP_W-1:0] cur_flip;
   logic [DW-1:0]               cur_lat_width, cur_out_width, cur_out_height;

   always_comb begin
      if (in_fs_ff) begin
         cur_src_col = '0;
         cur_src_row = '0;
         cur_out_col = '0;
         cur_out_row = '0;
         cur_next_col = geo_first_col_ff;
         cur_next_row = geo_first_row_ff;
         cur_hstep = geo_hstep_ff;
         cur_vstep = geo_vstep_ff;
         cur_first_col = geo_first_col_ff;
         cur_format = geo_format_ff;
         cur_flip = geo_flip_ff;
         cur_lat_width = geo_w_ff;
         cur_out_width = geo_size[0];
         cur_out_height = geo_size[1];
      end else begin
         cur_src_col = src_col_ff;
         cur_src_row = src_row_ff;
         cur_out_col = out_col_ff;
         cur_out_row = out_row_ff;
         cur_next_col = next_col_ff;
         cur_next_row = next_row_ff;
         cur_hstep = lat_hstep_ff;
         cur_vstep = lat_vstep_ff;
         cur_first_col = lat_first_col_ff;
         cur_format = lat_format_ff;
         cur_flip = lat_flip_ff;
         cur_lat_width = lat_width_ff;
         cur_out_width = out_width_ff;
         cur_out_height = out_height_ff;
      end
   end

   // sampling decision and counter updates
   logic                row_hit;
   logic                line_end;
   logic                frame_last;
   logic [DW-1:0]       dest_x, dest_y;
   logic [DW-1:0]       src_col_in, src_row_in, out_col_in, out_row_in;
   logic [AW-1:0]       next_col_in, next_row_in;
   cdfs_pkg::rgb_type   rgb;

   assign row_hit = (cur_out_row < cur_out_height) && (AW'(cur_src_row) == cur_next_row);
   assign hit = row_hit && (cur_out_col < cur_out_width) && (AW'(cur_src_col) == cur_next_col);
   assign line_end = (cur_lat_width != '0) &&
                     (({1'b0, cur_src_col} + (DW + 1)'(1)) >= {1'b0, cur_lat_width});

   always_comb begin
      src_col_in = cur_src_col;
      src_row_in = cur_src_row;
      out_col_in = cur_out_col;
      out_row_in = cur_out_row;
      next_col_in = cur_next_col;
      next_row_in = cur_next_row;
      if (hit) begin
         out_col_in = cur_out_col + DW'(1);
         next_col_in = cur_next_col + AW'(cur_hstep);
      end
      if (line_end) begin
         src_col_in = '0;
         if (cur_src_row < MAX_DIM_D) begin
            src_row_in = cur_src_row + DW'(1);
         end
         if (row_hit) begin
            out_row_in = cur_out_row + DW'(1);
            next_row_in = cur_next_row + AW'(cur_vstep);
         end
         out_col_in = '0;
         next_col_in = cur_first_col;
      end else if (cur_lat_width != '0) begin
         src_col_in = cur_src_col + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         next_col_ff <= '0;
         next_row_ff <= '0;
         lat_hstep_ff <= '0;
         lat_vstep_ff <= '0;
         lat_first_col_ff <= '0;
         lat_format_ff <= '0;
         lat_flip_ff <= '0;
         lat_width_ff <= '0;
         out_width_ff <= '0;
         out_height_ff <= '0;
      end else if (advance) begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         next_col_ff <= next_col_in;
         next_row_ff <= next_row_in;
         lat_hstep_ff <= cur_hstep;
         lat_vstep_ff <= cur_vstep;
         lat_first_col_ff <= cur_first_col;
         lat_format_ff <= cur_format;
         lat_flip_ff <= cur_flip;
         lat_width_ff <= cur_lat_width;
         out_width_ff <= cur_out_width;
         out_height_ff <= cur_out_height;
      end
   end

   // result payload: color, mirrored position, last mark
   assign rgb = cdfs_pkg::unpack_pixel(cur_format, in_px_ff);
   assign dest_x = cur_flip[cdfs_pkg::FLIP_COLS_BIT] ?
                   (cur_out_width - DW'(1) - cur_out_col) : cur_out_col;
   assign dest_y = cur_flip[cdfs_pkg::FLIP_ROWS_BIT] ?
                   (cur_out_height - DW'(1) - cur_out_row) : cur_out_row;
   assign frame_last = ((cur_out_row + DW'(1)) == cur_out_height) &&
                       ((cur_out_col + DW'(1)) == cur_out_width);

   logic [cdfs_pkg::COLOR_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [cdfs_pkg::COORD_W-1:0] rsp_dest_x_ff, rsp_dest_y_ff;
   logic                         rsp_frame_last_ff;

   always_ff @(posedge clock) begin
      if (advance && hit) begin
         rsp_red_ff <= rgb.red;
         rsp_green_ff <= rgb.green;
         rsp_blue_ff <= rgb.blue;
         rsp_dest_x_ff <= cdfs_pkg::COORD_W'(dest_x);
         rsp_dest_y_ff <= cdfs_pkg::COORD_W'(dest_y);
         rsp_frame_last_ff <= frame_last;
      end
   end

   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.red = rsp_red_ff;
   assign rsp_ch.green = rsp_green_ff;
   assign rsp_ch.blue = rsp_blue_ff;
   assign rsp_ch.dest_x = rsp_dest_x_ff;
   assign rsp_ch.dest_y = rsp_dest_y_ff;
   assign rsp_ch.frame_last = rsp_frame_last_ff;

endmodule
